// File: src/pfp_pkg.sv
// Shared types and constants of the page frame pool block.
// No dependencies; used by page_frame_pool_watermark_core.
`default_nettype none

package pfp_pkg;

  // fixed field widths of the request and result items
  localparam int ORDER_W  = 4;
  localparam int KIND_W   = 3;
  localparam int MARK_W   = 13;
  localparam int STATUS_W = 3;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_DISABLED    = 3'd1,
    ST_UNSUPPORTED = 3'd2,
    ST_BELOW_LOW   = 3'd3,
    ST_EMPTY       = 3'd4,
    ST_FULL        = 3'd5
  } status_t;

  // request operation codes
  localparam logic OP_TAKE = 1'b0;
  localparam logic OP_GIVE = 1'b1;

  // configuration register indexes (word address)
  localparam logic [2:0] REG_POOL_ENABLE = 3'd0;
  localparam logic [2:0] REG_HIGH_MARK0  = 3'd1;
  localparam logic [2:0] REG_LOW_MARK0   = 3'd2;
  localparam logic [2:0] REG_HIGH_MARK1  = 3'd3;
  localparam logic [2:0] REG_LOW_MARK1   = 3'd4;

  // reset values of the watermarks
  localparam logic [MARK_W-1:0] HIGH_MARK0_RST = 13'd4096;
  localparam logic [MARK_W-1:0] LOW_MARK0_RST  = 13'd2048;
  localparam logic [MARK_W-1:0] HIGH_MARK1_RST = 13'd1024;
  localparam logic [MARK_W-1:0] LOW_MARK1_RST  = 13'd512;

endpackage

`default_nettype wire

// File: src/pfp_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; holds the frames of all pools.
`default_nettype none

module pfp_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, or read into the output register; rdata holds otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// File: src/page_frame_pool_watermark_core.sv
// Top level of the page frame pool with low and high watermarks.
// Depends on pfp_pkg and pfp_ram.
`default_nettype none

// Keeps one FIFO of page frame numbers per (block order, migrate type) pair.
// A take pops the oldest frame of the addressed pool, a give pushes one.
// One request item is accepted every clock cycle unless the result path stalls.
// Its result passes through stage one, which covers the registered read of the
// shared frame RAM, and then the result register. Per-pool head, tail and count
// live in flip-flops and are updated at acceptance, so back-to-back requests to
// one pool see each other. The frame RAM is not cleared after reset; no clearing
// pass is run. Configuration is to be written through the register port only
// while no item is in flight; the block itself does not enforce this.
module page_frame_pool_watermark_core #(
  parameter int POOL_DEPTH      = 4096,
  parameter int NUM_TYPES       = 2,
  parameter int NUM_POOL_ORDERS = 2,
  parameter int FRAME_BITS      = 36,
  localparam int IN_W  = ((8 + FRAME_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((FRAME_BITS + 17 + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // request channel
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // block_order[3:0], migrate_kind[6:4], priority_req[7], frame_in above
  input  wire logic [IN_W-1:0]  in_tdata,
  // operation (0 take, 1 give)
  input  wire logic             in_tuser,
  // result channel
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // status[2:0], frame_out, wake_filler, level[12:0], zero padding
  output logic      [OUT_W-1:0] out_tdata,
  // configuration port
  input  wire logic             cfg_psel,
  input  wire logic             cfg_penable,
  input  wire logic             cfg_pwrite,
  input  wire logic [4:0]       cfg_paddr,
  input  wire logic [31:0]      cfg_pwdata,
  output logic      [31:0]      cfg_prdata,
  output logic                  cfg_pready
);

  localparam int NUM_POOLS = NUM_POOL_ORDERS * NUM_TYPES;
  localparam int PW        = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int IDX_W     = $clog2(POOL_DEPTH);
  localparam int CNT_W     = $clog2(POOL_DEPTH + 1);
  localparam int CMP_W     = (CNT_W > pfp_pkg::MARK_W) ? CNT_W : pfp_pkg::MARK_W;
  localparam int MEM_DEPTH = NUM_POOLS * POOL_DEPTH;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int MW        = pfp_pkg::MARK_W;

  // configuration registers
  logic          enable_r;
  logic [MW-1:0] high0_r, low0_r, high1_r, low1_r;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      high0_r  <= pfp_pkg::HIGH_MARK0_RST;
      low0_r   <= pfp_pkg::LOW_MARK0_RST;
      high1_r  <= pfp_pkg::HIGH_MARK1_RST;
      low1_r   <= pfp_pkg::LOW_MARK1_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        pfp_pkg::REG_POOL_ENABLE: enable_r <= cfg_pwdata[0];
        pfp_pkg::REG_HIGH_MARK0:  high0_r  <= cfg_pwdata[MW-1:0];
        pfp_pkg::REG_LOW_MARK0:   low0_r   <= cfg_pwdata[MW-1:0];
        pfp_pkg::REG_HIGH_MARK1:  high1_r  <= cfg_pwdata[MW-1:0];
        pfp_pkg::REG_LOW_MARK1:   low1_r   <= cfg_pwdata[MW-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_paddr[4:2])
      pfp_pkg::REG_POOL_ENABLE: cfg_prdata = {31'd0, enable_r};
      pfp_pkg::REG_HIGH_MARK0:  cfg_prdata = 32'(high0_r);
      pfp_pkg::REG_LOW_MARK0:   cfg_prdata = 32'(low0_r);
      pfp_pkg::REG_HIGH_MARK1:  cfg_prdata = 32'(high1_r);
      pfp_pkg::REG_LOW_MARK1:   cfg_prdata = 32'(low1_r);
      default:                  cfg_prdata = 32'd0;
    endcase
  end

  // request fields
  logic                       req_op;
  logic [pfp_pkg::ORDER_W-1:0] req_order;
  logic [pfp_pkg::KIND_W-1:0]  req_kind;
  logic                       req_prio;
  logic [FRAME_BITS-1:0]      req_frame;

  assign req_op    = in_tuser;
  assign req_order = in_tdata[3:0];
  assign req_kind  = in_tdata[6:4];
  assign req_prio  = in_tdata[7];
  assign req_frame = in_tdata[8 +: FRAME_BITS];

  // per-pool FIFO control
  logic [IDX_W-1:0] head_r [NUM_POOLS];
  logic [IDX_W-1:0] tail_r [NUM_POOLS];
  logic [CNT_W-1:0] cnt_r  [NUM_POOLS];

  // pipeline handshake
  logic s1_v_r, out_v_r, s1_adv, accept;

  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_adv;
  assign accept    = in_tvalid && in_tready;

  // pool select and watermark compare
  logic             supported;
  logic [7:0]       pool_wide;
  logic [PW-1:0]    pool;
  logic [CNT_W-1:0] cnt_cur;
  logic [IDX_W-1:0] head_cur, tail_cur, head_nxt, tail_nxt;
  logic [MW-1:0]    low_sel, high_sel;
  logic             below, full, empty, wake_pop;

  assign supported = (5'(req_order) < 5'(NUM_POOL_ORDERS)) &&
                     (4'(req_kind) < 4'(NUM_TYPES));
  assign pool_wide = 8'(req_order) * 8'(NUM_TYPES) + 8'(req_kind);
  assign pool      = supported ? pool_wide[PW-1:0] : '0;
  assign cnt_cur   = cnt_r[pool];
  assign head_cur  = head_r[pool];
  assign tail_cur  = tail_r[pool];
  assign head_nxt  = (head_cur == IDX_W'(POOL_DEPTH - 1)) ? '0 : head_cur + 1'b1;
  assign tail_nxt  = (tail_cur == IDX_W'(POOL_DEPTH - 1)) ? '0 : tail_cur + 1'b1;
  assign low_sel   = (req_order == '0) ? low0_r : low1_r;
  assign high_sel  = (req_order == '0) ? high0_r : high1_r;
  assign below     = CMP_W'(cnt_cur) < CMP_W'(low_sel);
  assign full      = (CMP_W'(cnt_cur) >= CMP_W'(high_sel)) ||
                     (cnt_cur == CNT_W'(POOL_DEPTH));
  assign empty     = (cnt_cur == '0);
  assign wake_pop  = CMP_W'(cnt_cur - 1'b1) < CMP_W'(low_sel);

  // request decision
  pfp_pkg::status_t status;
  logic             do_pop, do_push, wake;
  logic [CNT_W-1:0] cnt_nxt;
  logic [MW-1:0]    level;

  always_comb begin
    status  = pfp_pkg::ST_OK;
    do_pop  = 1'b0;
    do_push = 1'b0;
    wake    = 1'b0;
    cnt_nxt = cnt_cur;
    if (!supported) begin
      status = enable_r ? pfp_pkg::ST_UNSUPPORTED : pfp_pkg::ST_DISABLED;
    end else if (!enable_r) begin
      status = pfp_pkg::ST_DISABLED;
    end else if (req_op == pfp_pkg::OP_TAKE) begin
      if (!req_prio && below) begin
        status = pfp_pkg::ST_BELOW_LOW;
      end else if (empty) begin
        status = pfp_pkg::ST_EMPTY;
        wake   = below;
      end else begin
        do_pop  = 1'b1;
        cnt_nxt = cnt_cur - 1'b1;
        wake    = wake_pop;
      end
    end else begin
      if (full) begin
        status = pfp_pkg::ST_FULL;
      end else begin
        do_push = 1'b1;
        cnt_nxt = cnt_cur + 1'b1;
      end
    end
    level = supported ? MW'(cnt_nxt) : '0;
  end

  // pool control update at acceptance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_POOLS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else if (accept) begin
      cnt_r[pool] <= cnt_nxt;
      if (do_pop) begin
        head_r[pool] <= head_nxt;
      end
      if (do_push) begin
        tail_r[pool] <= tail_nxt;
      end
    end
  end

  // frame storage of all pools
  logic [AW-1:0]         ram_addr;
  logic [FRAME_BITS-1:0] ram_rdata;

  assign ram_addr = AW'(pool) * AW'(POOL_DEPTH) + AW'(do_pop ? head_cur : tail_cur);

  pfp_ram #(
    .WIDTH (FRAME_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .en    (accept && (do_pop || do_push)),
    .we    (do_push),
    .addr  (ram_addr),
    .wdata (req_frame),
    .rdata (ram_rdata)
  );

  // stage one: decision waiting for the frame read
  pfp_pkg::status_t s1_status_r;
  logic             s1_pop_r, s1_wake_r;
  logic [MW-1:0]    s1_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= status;
      s1_pop_r    <= do_pop;
      s1_wake_r   <= wake;
      s1_level_r  <= level;
    end
  end

  // result register
  pfp_pkg::status_t      out_status_r;
  logic [FRAME_BITS-1:0] out_frame_r;
  logic                  out_wake_r;
  logic [MW-1:0]         out_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r <= s1_status_r;
      out_frame_r  <= s1_pop_r ? ram_rdata : '0;
      out_wake_r   <= s1_wake_r;
      out_level_r  <= s1_level_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_W'({out_level_r, out_wake_r, out_frame_r, out_status_r});

  // a handed-out frame only comes with a successful request
  a_frame_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_frame_r != '0) |-> out_status_r == pfp_pkg::ST_OK)
    else $error("frame_out nonzero on a refused request");

  // wake is raised only by a take that reached the pool
  a_wake_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_wake_r |->
      out_status_r == pfp_pkg::ST_OK || out_status_r == pfp_pkg::ST_EMPTY)
    else $error("wake_filler set on a refused request");

  // a pop never happens on an empty pool
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    accept && do_pop |-> !empty)
    else $error("pop from empty pool");

  // pool counts stay within the pool depth
  for (genvar g = 0; g < NUM_POOLS; g++) begin : g_cnt_chk
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
      CMP_W'(cnt_r[g]) <= CMP_W'(POOL_DEPTH))
      else $error("pool count above depth");
  end

endmodule

`default_nettype wire

// File: tb/sv/page_frame_pool_watermark_core_tb.sv
// Self-checking testbench for page_frame_pool_watermark_core.
// Depends on pfp_pkg and the core; drives the request stream and the register
// port and checks every result item against an in-bench model of the four pools.
`timescale 1ns / 100ps

module page_frame_pool_watermark_core_tb;

  localparam int DEPTH       = 4096;
  localparam int FRAME_W     = 36;
  localparam int POOL_ORDERS = 2;
  localparam int NUM_KINDS   = 2;
  localparam int IN_W        = 48;
  localparam int OUT_W       = 56;
  localparam int SETTLE      = 6;
  localparam int DRAIN_MAX   = 20000;
  localparam int HOLD_LEN    = 200;
  localparam int ORDER_W     = pfp_pkg::ORDER_W;
  localparam int KIND_W      = pfp_pkg::KIND_W;
  localparam int MARK_W      = pfp_pkg::MARK_W;

  typedef struct {
    logic               op;
    logic [ORDER_W-1:0] order;
    logic [KIND_W-1:0]  kind;
    logic               prio;
    logic [FRAME_W-1:0] frame;
  } pool_req_t;

  typedef struct {
    pfp_pkg::status_t   status;
    logic [FRAME_W-1:0] frame;
    logic               wake;
    logic [MARK_W-1:0]  level;
  } pool_result_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_psel;
  logic             cfg_penable;
  logic             cfg_pwrite;
  logic [4:0]       cfg_paddr;
  logic [31:0]      cfg_pwdata;
  logic [31:0]      cfg_prdata;
  logic             cfg_pready;

  // pool model: one frame queue per pool plus the register copies
  logic [FRAME_W-1:0] pool_frames[POOL_ORDERS*NUM_KINDS][$];
  logic               pool_en;
  logic [MARK_W-1:0]  high_mark[POOL_ORDERS];
  logic [MARK_W-1:0]  low_mark[POOL_ORDERS];

  pool_result_t expected_results[$];
  pool_result_t exp_res;
  int           err_count;
  int           result_idx;
  bit           tx_nowait;
  bit           rx_nowait;
  bit           hold_req;

  page_frame_pool_watermark_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #10ms;
    $display("page_frame_pool_watermark_core test failed");
    $finish;
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch at result %0d, %s: got 0x%0h want 0x%0h", result_idx, what, got, want);
    err_count++;
  endtask

  function automatic int draw_gap(bit nowait);
    return nowait ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic logic [FRAME_W-1:0] rand_frame();
    return {4'($urandom), 32'($urandom)};
  endfunction

  // expected result of one request, updates the pool model
  function automatic pool_result_t predict_pool_step(pool_req_t r);
    pool_result_t res;
    int p;
    int hi;
    int lo;
    int cnt;
    res.status = pfp_pkg::ST_OK;
    res.frame  = '0;
    res.wake   = 1'b0;
    res.level  = '0;
    if (r.order >= POOL_ORDERS || r.kind >= NUM_KINDS) begin
      res.status = pool_en ? pfp_pkg::ST_UNSUPPORTED : pfp_pkg::ST_DISABLED;
      return res;
    end
    p  = int'(r.order) * NUM_KINDS + int'(r.kind);
    hi = (high_mark[r.order] > DEPTH) ? DEPTH : int'(high_mark[r.order]);
    lo = int'(low_mark[r.order]);
    cnt = pool_frames[p].size();
    if (!pool_en) begin
      res.status = pfp_pkg::ST_DISABLED;
    end else if (r.op == pfp_pkg::OP_TAKE) begin
      if (!r.prio && cnt < lo) begin
        res.status = pfp_pkg::ST_BELOW_LOW;
      end else begin
        if (cnt == 0) begin
          res.status = pfp_pkg::ST_EMPTY;
        end else begin
          res.frame = pool_frames[p].pop_front();
        end
        res.wake = (pool_frames[p].size() < lo);
      end
    end else begin
      if (cnt >= hi) begin
        res.status = pfp_pkg::ST_FULL;
      end else begin
        pool_frames[p].push_back(r.frame);
      end
    end
    res.level = MARK_W'(pool_frames[p].size());
    return res;
  endfunction

  function automatic logic [31:0] reg_value(logic [2:0] idx);
    case (idx)
      pfp_pkg::REG_POOL_ENABLE: return {31'd0, pool_en};
      pfp_pkg::REG_HIGH_MARK0:  return {19'd0, high_mark[0]};
      pfp_pkg::REG_LOW_MARK0:   return {19'd0, low_mark[0]};
      pfp_pkg::REG_HIGH_MARK1:  return {19'd0, high_mark[1]};
      pfp_pkg::REG_LOW_MARK1:   return {19'd0, low_mark[1]};
      default:                  return 32'd0;
    endcase
  endfunction

  // one register transfer: setup and access phases, then the bus goes idle
  task automatic cfg_access(bit wr, logic [2:0] idx, logic [31:0] val);
    logic [31:0] rd;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (wr) begin
      case (idx)
        pfp_pkg::REG_POOL_ENABLE: pool_en      = val[0];
        pfp_pkg::REG_HIGH_MARK0:  high_mark[0] = val[MARK_W-1:0];
        pfp_pkg::REG_LOW_MARK0:   low_mark[0]  = val[MARK_W-1:0];
        pfp_pkg::REG_HIGH_MARK1:  high_mark[1] = val[MARK_W-1:0];
        pfp_pkg::REG_LOW_MARK1:   low_mark[1]  = val[MARK_W-1:0];
        default: ;
      endcase
    end else if (rd !== reg_value(idx)) begin
      report_mismatch($sformatf("register %0d read", idx), rd, reg_value(idx));
    end
    @(posedge clk);
  endtask

  // stop offering items and wait until every result has come back
  task automatic wait_drain();
    int guard;
    in_tvalid <= 1'b0;
    guard = 0;
    while (expected_results.size() != 0 && guard < DRAIN_MAX) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // write all registers while idle and read each one back
  task automatic set_pool_config(logic en, int h0, int l0, int h1, int l1);
    wait_drain();
    cfg_access(1'b1, pfp_pkg::REG_POOL_ENABLE, {31'd0, en});
    cfg_access(1'b1, pfp_pkg::REG_HIGH_MARK0, h0);
    cfg_access(1'b1, pfp_pkg::REG_LOW_MARK0, l0);
    cfg_access(1'b1, pfp_pkg::REG_HIGH_MARK1, h1);
    cfg_access(1'b1, pfp_pkg::REG_LOW_MARK1, l1);
    cfg_access(1'b0, pfp_pkg::REG_POOL_ENABLE, '0);
    cfg_access(1'b0, pfp_pkg::REG_HIGH_MARK0, '0);
    cfg_access(1'b0, pfp_pkg::REG_LOW_MARK0, '0);
    cfg_access(1'b0, pfp_pkg::REG_HIGH_MARK1, '0);
    cfg_access(1'b0, pfp_pkg::REG_LOW_MARK1, '0);
  endtask

  // offer one request item and record its expected result at acceptance
  task automatic send_req(logic op, logic [ORDER_W-1:0] order, logic [KIND_W-1:0] kind,
                          logic prio, logic [FRAME_W-1:0] frame);
    int gap;
    pool_req_t req;
    gap = draw_gap(tx_nowait);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'd0, frame, prio, kind, order};
    do @(posedge clk); while (!in_tready);
    req.op    = op;
    req.order = order;
    req.kind  = kind;
    req.prio  = prio;
    req.frame = frame;
    expected_results.push_back(predict_pool_step(req));
  endtask

  // random requests, mostly to served pools, with some unsupported ones
  task automatic send_random(int count, int give_pct, int bad_pct, int prio_pct);
    int i;
    logic op;
    logic [ORDER_W-1:0] order;
    logic [KIND_W-1:0] kind;
    logic prio;
    for (i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        tx_nowait = ($urandom_range(0, 3) == 0);
        rx_nowait = ($urandom_range(0, 3) == 0);
      end
      op    = ($urandom_range(0, 99) < give_pct) ? pfp_pkg::OP_GIVE : pfp_pkg::OP_TAKE;
      order = ORDER_W'($urandom_range(0, 1));
      kind  = KIND_W'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < bad_pct) begin
        case ($urandom_range(0, 2))
          0: order = ORDER_W'($urandom_range(2, 15));
          1: kind = KIND_W'($urandom_range(2, 7));
          default: begin
            order = ORDER_W'($urandom_range(2, 15));
            kind  = KIND_W'($urandom_range(2, 7));
          end
        endcase
      end
      prio = ($urandom_range(0, 99) < prio_pct);
      send_req(op, order, kind, prio, rand_frame());
    end
    tx_nowait = 1'b0;
    rx_nowait = 1'b0;
  endtask

  // result sink with random stalls and an occasional long hold-off
  initial begin : result_sink
    int stall;
    forever begin
      if (hold_req) begin
        stall = HOLD_LEN;
        hold_req = 1'b0;
      end else begin
        stall = draw_gap(rx_nowait);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // compare every accepted result item with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", out_tdata, 0);
      end else begin
        exp_res = expected_results.pop_front();
        if (out_tdata[2:0] !== exp_res.status)
          report_mismatch("status", out_tdata[2:0], exp_res.status);
        if (out_tdata[38:3] !== exp_res.frame)
          report_mismatch("frame_out", out_tdata[38:3], exp_res.frame);
        if (out_tdata[39] !== exp_res.wake)
          report_mismatch("wake_filler", out_tdata[39], exp_res.wake);
        if (out_tdata[52:40] !== exp_res.level)
          report_mismatch("level", out_tdata[52:40], exp_res.level);
      end
      result_idx++;
    end
  end

  // reset values read back, requests refused while disabled
  task automatic test_reset_state();
    cfg_access(1'b0, pfp_pkg::REG_POOL_ENABLE, '0);
    cfg_access(1'b0, pfp_pkg::REG_HIGH_MARK0, '0);
    cfg_access(1'b0, pfp_pkg::REG_LOW_MARK0, '0);
    cfg_access(1'b0, pfp_pkg::REG_HIGH_MARK1, '0);
    cfg_access(1'b0, pfp_pkg::REG_LOW_MARK1, '0);
    send_req(pfp_pkg::OP_TAKE, 4'd0, 3'd0, 1'b1, '0);
    send_req(pfp_pkg::OP_GIVE, 4'd1, 3'd1, 1'b0, '1);
    send_req(pfp_pkg::OP_TAKE, 4'd15, 3'd7, 1'b0, '0);
  endtask

  // directed walk through every status of an enabled block and the watermark edges
  task automatic test_directed_pool_ops();
    set_pool_config(1'b1, 3, 1, 0, 0);
    // unsupported order, kind, both
    send_req(pfp_pkg::OP_TAKE, 4'd2, 3'd0, 1'b0, '0);
    send_req(pfp_pkg::OP_GIVE, 4'd0, 3'd2, 1'b1, 36'h5_0000_000A);
    send_req(pfp_pkg::OP_TAKE, 4'd15, 3'd7, 1'b1, '1);
    // empty pool: below low for normal requester, empty for priority one
    send_req(pfp_pkg::OP_TAKE, 4'd0, 3'd0, 1'b0, '0);
    send_req(pfp_pkg::OP_TAKE, 4'd0, 3'd0, 1'b1, '0);
    // fill to the high mark, then one give too many
    send_req(pfp_pkg::OP_GIVE, 4'd0, 3'd0, 1'b0, '1);
    send_req(pfp_pkg::OP_GIVE, 4'd0, 3'd0, 1'b1, '0);
    send_req(pfp_pkg::OP_GIVE, 4'd0, 3'd0, 1'b0, 36'hA_5A5A_5A5A);
    send_req(pfp_pkg::OP_GIVE, 4'd0, 3'd0, 1'b0, 36'h1_2345_6789);
    // drain in order, wake once below the low mark
    send_req(pfp_pkg::OP_TAKE, 4'd0, 3'd0, 1'b0, '1);
    send_req(pfp_pkg::OP_TAKE, 4'd0, 3'd0, 1'b1, '0);
    send_req(pfp_pkg::OP_TAKE, 4'd0, 3'd0, 1'b0, '0);
    send_req(pfp_pkg::OP_TAKE, 4'd0, 3'd0, 1'b1, '0);
    // zero high mark refuses every give, zero low mark never wakes
    send_req(pfp_pkg::OP_GIVE, 4'd1, 3'd1, 1'b0, 36'h8_0000_0001);
    send_req(pfp_pkg::OP_TAKE, 4'd1, 3'd1, 1'b0, '0);
    send_req(pfp_pkg::OP_GIVE, 4'd1, 3'd0, 1'b1, 36'h7_FFFF_FFFE);
    // other order-0 pool
    send_req(pfp_pkg::OP_GIVE, 4'd0, 3'd1, 1'b0, 36'h8_0000_0001);
    send_req(pfp_pkg::OP_TAKE, 4'd0, 3'd1, 1'b1, '0);
  endtask

  // small marks so pools swing between empty, below low and full
  task automatic test_random_mixed();
    set_pool_config(1'b1, 24, 4, 12, 2);
    send_random(120, 60, 10, 30);
    send_random(130, 40, 10, 50);
  endtask

  // long receiver hold-off fills the pipeline, then sender waits for all results
  task automatic test_backpressure();
    hold_req = 1'b1;
    tx_nowait = 1'b1;
    send_random(40, 55, 5, 50);
    wait_drain();
    send_random(20, 50, 5, 50);
  endtask

  // disabled block with content still reports the level
  task automatic test_disabled_with_content();
    set_pool_config(1'b0, 24, 4, 12, 2);
    send_random(40, 50, 20, 50);
  endtask

  // extreme marks: everything full and below low, then nothing limits
  task automatic test_mark_extremes();
    set_pool_config(1'b1, 0, 4096, 0, 4096);
    send_random(80, 40, 5, 60);
    set_pool_config(1'b1, 4096, 0, 4096, 0);
    send_random(100, 55, 5, 20);
  endtask

  // a few random watermark settings
  task automatic test_random_marks();
    int r;
    for (r = 0; r < 3; r++) begin
      set_pool_config(1'b1, $urandom_range(0, 48), $urandom_range(0, 24),
                      $urandom_range(0, 48), $urandom_range(0, 24));
      send_random(60, 50, 5, 40);
    end
  endtask

  // test sequence
  initial begin
    err_count   = 0;
    result_idx  = 0;
    tx_nowait   = 1'b0;
    rx_nowait   = 1'b0;
    hold_req    = 1'b0;
    pool_en      = 1'b0;
    high_mark[0] = pfp_pkg::HIGH_MARK0_RST;
    low_mark[0]  = pfp_pkg::LOW_MARK0_RST;
    high_mark[1] = pfp_pkg::HIGH_MARK1_RST;
    low_mark[1]  = pfp_pkg::LOW_MARK1_RST;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_directed_pool_ops();
    test_random_mixed();
    test_backpressure();
    test_disabled_with_content();
    test_mark_extremes();
    test_random_marks();
    wait_drain();

    if (expected_results.size() != 0)
      report_mismatch("results never arrived", expected_results.size(), 0);
    if (err_count == 0)
      $display("page_frame_pool_watermark_core test passed");
    else
      $display("page_frame_pool_watermark_core test failed");
    $finish;
  end

endmodule
